FILE: rtl/core/itc_pkg.sv
// Shared constants and types of the three-channel interval timer.
`default_nettype none
package itc_pkg;

   localparam int TICK_WIDTH   = 32;
   localparam int NUM_COUNTERS = 3;
   localparam int QUEUE_DEPTH  = 2;
   localparam int WIDE_W       = (TICK_WIDTH > 17) ? TICK_WIDTH : 17;

   localparam logic [16:0] BIN_SPAN = 17'h10000;
   localparam logic [16:0] BCD_SPAN = 17'd10000;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;

   localparam logic [2:0] PORT_CONTROL = 3'd3;
   localparam logic [1:0] READ_BACK_SEL = 2'd3;
   localparam logic [7:0] CONTROL_READ_BYTE = 8'hff;

   typedef enum logic [2:0] {
      K_NOP, K_TICK, K_RD_CTR, K_RD_CTRL, K_RD_SYS, K_WR_CTR, K_WR_CTRL, K_WR_SYS
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [1:0] chan;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic                  start;
      logic [TICK_WIDTH-1:0] dividend;
      logic [16:0]           divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [16:0] rem;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_RB, ST_CNT, ST_DIV, ST_CNT_FIN, ST_OUT2, ST_OUT2_FIN,
      ST_BCD, ST_READ_FIN, ST_RESULT
   } state_type;

   typedef enum logic [1:0] {P_READ, P_LATCH, P_RB, P_OUT} purpose_type;

endpackage
`default_nettype wire

FILE: rtl/core/itc_front.sv
// Front end: classifies incoming beats and queues them for the engine.
`default_nettype none
module itc_front
   import itc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_command,
   input  wire logic [2:0] req_port_select,
   input  wire logic [7:0] req_write_data,
   output item_type        q_item,
   output logic            q_valid,
   input  wire logic       q_pop
);

   item_type   items_ff [QUEUE_DEPTH];
   logic       rd_ptr_ff, wr_ptr_ff;
   logic [1:0] count_ff;
   item_type   cls;
   logic       push;

   always_comb begin
      cls.chan = req_port_select[1:0];
      cls.data = req_write_data;
      case (req_command)
         CMD_TICK: cls.kind = K_TICK;
         CMD_READ: begin
            if (req_port_select inside {[3'd0:3'd2]}) cls.kind = K_RD_CTR;
            else if (req_port_select == PORT_CONTROL) cls.kind = K_RD_CTRL;
            else cls.kind = K_RD_SYS;
         end
         CMD_WRITE: begin
            if (req_port_select inside {[3'd0:3'd2]}) cls.kind = K_WR_CTR;
            else if (req_port_select == PORT_CONTROL) cls.kind = K_WR_CTRL;
            else cls.kind = K_WR_SYS;
         end
         default: cls.kind = K_NOP;
      endcase
   end

   assign req_stall = (count_ff == 2'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = items_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) items_ff[wr_ptr_ff] <= cls;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (q_pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(q_pop);
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/itc_div.sv
// Restoring remainder unit, one dividend bit per cycle.
`default_nettype none
module itc_div
   import itc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   localparam int STEP_W = $clog2(TICK_WIDTH);

   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [16:0]           rem_ff, rem_in, dvs_ff, dvs_in;
   logic [TICK_WIDTH-1:0] dq_ff, dq_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [17:0]           sh;

   assign sh = {rem_ff, dq_ff[TICK_WIDTH-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      dq_in   = dq_ff;
      step_in = step_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         rem_in  = 17'd0;
         dvs_in  = div_req.divisor;
         dq_in   = div_req.dividend;
         step_in = STEP_W'(TICK_WIDTH - 1);
      end else if (busy_ff) begin
         rem_in  = (sh >= {1'b0, dvs_ff}) ? 17'(sh - {1'b0, dvs_ff}) : sh[16:0];
         dq_in   = dq_ff << 1;
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      dq_ff   <= dq_in;
      step_ff <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.rem  = rem_ff;

endmodule
`default_nettype wire

FILE: rtl/core/itc_back.sv
// Back end: timer state, count evaluation sequencer and result register.
`default_nettype none
module itc_back
   import itc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire item_type    q_item,
   input  wire logic        q_valid,
   output logic             q_pop,
   output div_req_type      div_req,
   input  wire div_rsp_type div_rsp,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_read_data
);

   typedef logic [TICK_WIDTH-1:0] tick_type;

   function automatic logic [15:0] from_bcd(input logic [15:0] v);
      return 16'(v[3:0]) + 16'(v[7:4]) * 16'd10 + 16'(v[11:8]) * 16'd100 +
             16'(v[15:12]) * 16'd1000;
   endfunction

   function automatic logic [15:0] dd_adjust(input logic [15:0] v);
      logic [15:0] r;
      r = v;
      for (int i = 0; i < 4; i++) begin
         if (v[i*4 +: 4] >= 4'd5) r[i*4 +: 4] = v[i*4 +: 4] + 4'd3;
      end
      return r;
   endfunction

   tick_type    tick_ff, tick_in;
   logic        gate_ff, gate_in;
   tick_type    start_ff [NUM_COUNTERS];
   tick_type    start_in [NUM_COUNTERS];
   logic [15:0] reload_ff [NUM_COUNTERS];
   logic [15:0] reload_in [NUM_COUNTERS];
   logic [15:0] pend_ff [NUM_COUNTERS];
   logic [15:0] pend_in [NUM_COUNTERS];
   logic [2:0]  amode_ff [NUM_COUNTERS];
   logic [2:0]  amode_in [NUM_COUNTERS];
   logic [2:0]  pmode_ff [NUM_COUNTERS];
   logic [2:0]  pmode_in [NUM_COUNTERS];
   logic [1:0]  bcd_ff [NUM_COUNTERS];
   logic [1:0]  bcd_in [NUM_COUNTERS];
   logic [1:0]  acc_ff [NUM_COUNTERS];
   logic [1:0]  acc_in [NUM_COUNTERS];
   logic [3:0]  byte_ff [NUM_COUNTERS];
   logic [3:0]  byte_in [NUM_COUNTERS];
   logic [15:0] lcnt_ff [NUM_COUNTERS];
   logic [15:0] lcnt_in [NUM_COUNTERS];
   logic [7:0]  lstat_ff [NUM_COUNTERS];
   logic [7:0]  lstat_in [NUM_COUNTERS];
   logic [2:0]  lflag_ff [NUM_COUNTERS];
   logic [2:0]  lflag_in [NUM_COUNTERS];

   state_type   state_ff, state_in;
   purpose_type purpose_ff, purpose_in;
   item_type    item_ff, item_in;
   logic [1:0]  ch_ff, ch_in, ci;
   logic [15:0] val_ff, val_in, dd_ff, dd_in, dd_adj;
   logic [3:0]  ddc_ff, ddc_in;
   logic [7:0]  res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;

   logic              held, periodic, t_le_n, cnt_ready, rb_sel, rb_count, out_bit;
   tick_type          t;
   logic [15:0]       n, cnt_val, pv_new;
   logic [16:0]       m, pdiv;
   logic [2:0]        mode_red;
   logic [WIDE_W-1:0] tx, ex;
   logic [3:0]        bf;
   state_type         done_next;

   assign ci       = (ch_ff > 2'd2) ? 2'd0 : ch_ff;
   assign held     = (ci == 2'd2 && gate_ff) || (start_ff[ci] > tick_ff);
   assign t        = tick_ff - start_ff[ci];
   assign n        = reload_ff[ci];
   assign m        = bcd_ff[ci][0] ? BCD_SPAN : BIN_SPAN;
   assign pdiv     = (n != 16'd0) ? {1'b0, n} : m;
   assign periodic = amode_ff[ci][1];
   assign t_le_n   = (t <= TICK_WIDTH'(n));
   assign tx       = WIDE_W'(t);
   assign ex       = WIDE_W'(pdiv);
   assign mode_red = (amode_ff[ci][2:1] == 2'b11) ? {1'b0, amode_ff[ci][1:0]} : amode_ff[ci];
   assign rb_sel   = item_ff.data[3'(ch_ff) + 3'd1];
   assign rb_count = rb_sel && !item_ff.data[5] && !lflag_ff[ci][0];
   assign dd_adj   = dd_adjust(dd_ff);
   assign cnt_ready = (state_ff == ST_CNT && (held || t_le_n)) || (state_ff == ST_CNT_FIN);

   always_comb begin
      if (state_ff == ST_CNT_FIN) begin
         if (periodic)
            cnt_val = (div_rsp.rem == 17'd0) ? n : 16'(pdiv - div_rsp.rem);
         else
            cnt_val = 16'(m - 17'd1 - div_rsp.rem);
      end else begin
         cnt_val = held ? n : 16'(n - t[15:0]);
      end
   end

   always_comb begin
      if (state_ff == ST_OUT2_FIN) begin
         if (mode_red == 3'd2) out_bit = (div_rsp.rem + 17'd1) != pdiv;
         else out_bit = {1'b0, div_rsp.rem} < (({1'b0, pdiv} + 18'd1) >> 1);
      end else if (held) begin
         out_bit = (amode_ff[ci] != 3'd0);
      end else if (mode_red[2:1] == 2'b00) begin
         out_bit = (tx >= ex);
      end else begin
         out_bit = (tx != ex);
      end
   end

   always_comb begin
      case (purpose_ff)
         P_READ:  done_next = bcd_ff[ci][0] ? ST_BCD : ST_READ_FIN;
         P_RB:    done_next = ST_RB;
         default: done_next = ST_RESULT;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (q_valid) state_in = ST_DECODE;
         ST_DECODE: begin
            case (item_ff.kind)
               K_RD_CTR: begin
                  if (lflag_ff[ci][1]) state_in = ST_RESULT;
                  else if (lflag_ff[ci][0])
                     state_in = bcd_ff[ci][0] ? ST_BCD : ST_READ_FIN;
                  else state_in = ST_CNT;
               end
               K_RD_SYS: state_in = ST_OUT2;
               K_WR_CTRL: begin
                  if (item_ff.data[7:6] == READ_BACK_SEL) state_in = ST_RB;
                  else if (item_ff.data[5:4] == 2'd0)
                     state_in = lflag_ff[ci][0] ? ST_RESULT : ST_CNT;
                  else state_in = ST_RESULT;
               end
               default: state_in = ST_RESULT;
            endcase
         end
         ST_RB: begin
            if (ch_ff == 2'd3) state_in = ST_RESULT;
            else if (rb_count) state_in = ST_CNT;
         end
         ST_CNT: state_in = cnt_ready ? done_next : ST_DIV;
         ST_DIV: begin
            if (div_rsp.done) state_in = (purpose_ff == P_OUT) ? ST_OUT2_FIN : ST_CNT_FIN;
         end
         ST_CNT_FIN: state_in = done_next;
         ST_OUT2: begin
            if (held || mode_red[2] || !mode_red[1]) state_in = ST_RESULT;
            else state_in = ST_DIV;
         end
         ST_OUT2_FIN: state_in = ST_RESULT;
         ST_BCD: if (ddc_ff == 4'd0) state_in = ST_READ_FIN;
         ST_READ_FIN: state_in = ST_RESULT;
         ST_RESULT: if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      tick_in    = tick_ff;
      gate_in    = gate_ff;
      start_in   = start_ff;
      reload_in  = reload_ff;
      pend_in    = pend_ff;
      amode_in   = amode_ff;
      pmode_in   = pmode_ff;
      bcd_in     = bcd_ff;
      acc_in     = acc_ff;
      byte_in    = byte_ff;
      lcnt_in    = lcnt_ff;
      lstat_in   = lstat_ff;
      lflag_in   = lflag_ff;
      purpose_in = purpose_ff;
      item_in    = item_ff;
      ch_in      = ch_ff;
      val_in     = val_ff;
      dd_in      = 16'd0;
      ddc_in     = 4'd15;
      res_in     = res_ff;
      q_pop      = 1'b0;
      bf         = byte_ff[ci];
      pv_new     = pend_ff[ci];
      div_req.start    = 1'b0;
      div_req.dividend = periodic ? t : t - TICK_WIDTH'(n) - TICK_WIDTH'(1);
      div_req.divisor  = periodic ? pdiv : m;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (cnt_ready) begin
         case (purpose_ff)
            P_READ: val_in = cnt_val;
            P_RB: begin
               lcnt_in[ci]     = cnt_val;
               lflag_in[ci][0] = 1'b1;
               ch_in           = ch_ff + 2'd1;
            end
            default: begin
               lcnt_in[ci]     = cnt_val;
               lflag_in[ci][0] = 1'b1;
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_item;
               res_in  = 8'd0;
               case (q_item.kind)
                  K_WR_CTRL: ch_in = q_item.data[7:6];
                  K_RD_SYS, K_WR_SYS: ch_in = 2'd2;
                  default: ch_in = q_item.chan;
               endcase
            end
         end
         ST_DECODE: begin
            case (item_ff.kind)
               K_TICK: tick_in = tick_ff + TICK_WIDTH'(1);
               K_RD_CTRL: res_in = CONTROL_READ_BYTE;
               K_RD_CTR: begin
                  purpose_in = P_READ;
                  if (lflag_ff[ci][1]) begin
                     res_in          = lstat_ff[ci];
                     lflag_in[ci][1] = 1'b0;
                  end else begin
                     val_in = lcnt_ff[ci];
                  end
               end
               K_RD_SYS: purpose_in = P_OUT;
               K_WR_CTR: begin
                  if (bf[3:2] != 2'b00) begin
                     if (bf[2]) begin
                        pv_new = {pend_ff[ci][15:8], item_ff.data};
                        bf[2]  = 1'b0;
                     end else begin
                        pv_new = {item_ff.data, pend_ff[ci][7:0]};
                        bf[3]  = 1'b0;
                     end
                     pend_in[ci] = pv_new;
                     byte_in[ci] = bf;
                     if (bf[3:2] == 2'b00) begin
                        lflag_in[ci]  = 3'd0;
                        bcd_in[ci]    = {bcd_ff[ci][1], bcd_ff[ci][1]};
                        amode_in[ci]  = pmode_ff[ci];
                        start_in[ci]  = tick_ff + TICK_WIDTH'(1);
                        reload_in[ci] = bcd_ff[ci][1] ? from_bcd(pv_new) : pv_new;
                     end
                  end
               end
               K_WR_CTRL: begin
                  purpose_in = P_LATCH;
                  if (item_ff.data[7:6] == READ_BACK_SEL) begin
                     ch_in = 2'd0;
                  end else if (item_ff.data[5:4] != 2'd0) begin
                     byte_in[ci] = {item_ff.data[5], item_ff.data[4],
                                    item_ff.data[5], item_ff.data[4]};
                     acc_in[ci]      = item_ff.data[5:4];
                     lflag_in[ci][2] = 1'b1;
                     pmode_in[ci]    = item_ff.data[3:1];
                     bcd_in[ci]      = {item_ff.data[0], bcd_ff[ci][0]};
                  end
               end
               K_WR_SYS: begin
                  gate_in = item_ff.data[0];
                  if (!gate_ff && item_ff.data[0]) start_in[2] = tick_ff + TICK_WIDTH'(1);
               end
               default: ;
            endcase
         end
         ST_RB: begin
            if (ch_ff != 2'd3) begin
               purpose_in = P_RB;
               if (rb_sel && !item_ff.data[4] && !lflag_ff[ci][1]) begin
                  lstat_in[ci] = {1'b0, lflag_ff[ci][2], acc_ff[ci], amode_ff[ci],
                                  bcd_ff[ci][0]};
                  lflag_in[ci][1] = 1'b1;
               end
               if (!rb_count) ch_in = ch_ff + 2'd1;
            end
         end
         ST_CNT: div_req.start = !cnt_ready;
         ST_OUT2: begin
            div_req.dividend = t;
            div_req.divisor  = pdiv;
            if (held || mode_red[2] || !mode_red[1])
               res_in = {2'b00, out_bit, 4'b0000, gate_ff};
            else
               div_req.start = 1'b1;
         end
         ST_OUT2_FIN: res_in = {2'b00, out_bit, 4'b0000, gate_ff};
         ST_BCD: begin
            dd_in  = {dd_adj[14:0], val_ff[15]};
            ddc_in = ddc_ff - 4'd1;
            val_in = (ddc_ff == 4'd0) ? {dd_adj[14:0], val_ff[15]} : (val_ff << 1);
         end
         ST_READ_FIN: begin
            if (bf[0]) begin
               res_in = val_ff[7:0];
               bf[0]  = 1'b0;
            end else if (bf[1]) begin
               res_in = val_ff[15:8];
               bf[1]  = 1'b0;
            end else begin
               res_in = 8'd0;
            end
            byte_in[ci] = bf;
            if (bf[1:0] == 2'b00) lflag_in[ci][0] = 1'b0;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      lcnt_ff     <= lcnt_in;
      lstat_ff    <= lstat_in;
      item_ff     <= item_in;
      ch_ff       <= ch_in;
      val_ff      <= val_in;
      dd_ff       <= dd_in;
      ddc_ff      <= ddc_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         purpose_ff   <= P_READ;
         rsp_valid_ff <= 1'b0;
         tick_ff      <= '0;
         gate_ff      <= 1'b0;
         for (int i = 0; i < NUM_COUNTERS; i++) begin
            start_ff[i]  <= '0;
            reload_ff[i] <= 16'd0;
            pend_ff[i]   <= 16'd0;
            amode_ff[i]  <= 3'd0;
            pmode_ff[i]  <= 3'd0;
            bcd_ff[i]    <= 2'd0;
            acc_ff[i]    <= 2'd0;
            byte_ff[i]   <= 4'd0;
            lflag_ff[i]  <= 3'd0;
         end
      end else begin
         state_ff     <= state_in;
         purpose_ff   <= purpose_in;
         rsp_valid_ff <= rsp_valid_in;
         tick_ff      <= tick_in;
         gate_ff      <= gate_in;
         start_ff     <= start_in;
         reload_ff    <= reload_in;
         pend_ff      <= pend_in;
         amode_ff     <= amode_in;
         pmode_ff     <= pmode_in;
         bcd_ff       <= bcd_in;
         acc_ff       <= acc_in;
         byte_ff      <= byte_in;
         lflag_ff     <= lflag_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/interval_timer_three_channel.sv
// Top level of the three-channel interval timer.
// Each request beat is a tick, a port read, a port write or a no-op and gives one
// response beat carrying the byte read (zero for ticks, writes and no-ops). Beats enter
// a two-entry queue and are executed one at a time. A read or latch of a running count
// past its first period, or a read of the system port in modes 2 and 3, runs a
// one-bit-per-cycle remainder unit, and a BCD readout adds a digit conversion. A
// read-back command repeats the count evaluation for each selected channel, so a
// read-back of all three running channels is the slowest beat.
`default_nettype none
module interval_timer_three_channel
   import itc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_command,
   input  wire logic [2:0] req_port_select,
   input  wire logic [7:0] req_write_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_data
);

   item_type    q_item;
   logic        q_valid, q_pop;
   div_req_type div_req;
   div_rsp_type div_rsp;

   itc_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_command, .req_port_select,
      .req_write_data, .q_item, .q_valid, .q_pop
   );

   itc_div u_div (.clock, .reset, .div_req, .div_rsp);

   itc_back u_back (
      .clock, .reset, .q_item, .q_valid, .q_pop, .div_req, .div_rsp,
      .rsp_valid, .rsp_stall, .rsp_read_data
   );

   a_pop_valid: assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("Queue popped while empty.");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("Remainder unit restarted while busy.");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> $past(div_rsp.busy))
      else $error("Remainder done without a running division.");

endmodule
`default_nettype wire
